### rtl/core/hctd_pkg.sv
package hctd_pkg;

    // Fixed field widths
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;

    // Accumulator gives up and flags an error at this many bits
    localparam logic [LEN_W-1:0] MAX_CODE_BITS = 6'd32;

    // Bit position of the first stream bit in a data byte
    localparam logic [2:0] BYTE_TOP_BIT = 3'd7;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Action codes on the input channel
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_DATA  = 2'd2;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_LOAD,
        CMD_DATA
    } cmd_kind_t;

    // One classified command as it travels through the queue
    typedef struct packed {
        cmd_kind_t         kind;
        logic [7:0]        slot;
        logic [7:0]        symbol;
        logic [LEN_W-1:0]  length;
        logic [CODE_W-1:0] code;
        logic [7:0]        data;
    } cmd_t;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // One table entry as held in the slot memory
    typedef struct packed {
        logic [LEN_W-1:0]  length;
        logic [CODE_W-1:0] code;
        logic [7:0]        symbol;
    } slot_word_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_BIT,
        BK_SCAN,
        BK_RESOLVE,
        BK_FLUSH
    } bk_state_t;

endpackage

### rtl/core/hctd_front.sv
module hctd_front import hctd_pkg::*; #(
    parameter int TABLE_SLOTS = 256
) (
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_action,
    input  logic [7:0]        s_entry_slot,
    input  logic [7:0]        s_entry_symbol,
    input  logic [LEN_W-1:0]  s_entry_length,
    input  logic [CODE_W-1:0] s_entry_code,
    input  logic [7:0]        s_data_byte,
    input  q_status_t         q_status,
    output logic              q_push,
    output cmd_t              q_cmd
);

    logic              keep;
    logic [CODE_W-1:0] code_mask;

    // Take a beat whenever the queue has room
    assign s_ready = !q_status.full;

    // Drop code bits at and above the entry length
    always_comb begin
        for (int i = 0; i < CODE_W; i++) begin
            code_mask[i] = (LEN_W'(i) < s_entry_length);
        end
    end

    // Classify: unused actions and out-of-range loads go nowhere
    always_comb begin
        keep       = 1'b0;
        q_cmd.kind = CMD_DATA;
        unique case (s_action)
            ACT_CLEAR: begin
                keep       = 1'b1;
                q_cmd.kind = CMD_CLEAR;
            end
            ACT_LOAD: begin
                keep       = ({1'b0, s_entry_slot} < 9'(TABLE_SLOTS));
                q_cmd.kind = CMD_LOAD;
            end
            ACT_DATA: begin
                keep       = 1'b1;
                q_cmd.kind = CMD_DATA;
            end
            default: begin
                keep       = 1'b0;
                q_cmd.kind = CMD_DATA;
            end
        endcase
        q_cmd.slot   = s_entry_slot;
        q_cmd.symbol = s_entry_symbol;
        q_cmd.length = s_entry_length;
        q_cmd.code   = s_entry_code & code_mask;
        q_cmd.data   = s_data_byte;
    end

    assign q_push = s_valid && s_ready && keep;

endmodule

### rtl/core/hctd_cmd_fifo.sv
module hctd_cmd_fifo import hctd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      pop_cmd,
    output q_status_t status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_cmd      = entry_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/core/hctd_back.sv
module hctd_back import hctd_pkg::*; #(
    parameter int TABLE_SLOTS = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  q_status_t  q_status,
    input  cmd_t       q_cmd,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_symbol,
    output logic       m_code_error,
    output logic       m_last
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);

    // Slot memory: one write, one registered read per cycle
    slot_word_t mem [TABLE_SLOTS];
    slot_word_t rd_word_reg;
    logic [SLOT_W-1:0] rd_addr;
    logic              mem_wr;
    logic [SLOT_W-1:0] wr_slot;

    bk_state_t state_reg, state_next;

    logic [TABLE_SLOTS-1:0] valid_reg, valid_next;
    logic [SLOT_W-1:0]      hi_slot_reg, hi_slot_next;
    logic                   any_loaded_reg, any_loaded_next;
    logic [CODE_W-1:0]      acc_bits_reg, acc_bits_next;
    logic [LEN_W-1:0]       acc_cnt_reg, acc_cnt_next;
    logic [7:0]             byte_reg, byte_next;
    logic [2:0]             bit_idx_reg, bit_idx_next;
    logic [SLOT_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                   found_reg, found_next;
    logic [7:0]             found_sym_reg, found_sym_next;
    logic                   hold_valid_reg, hold_valid_next;
    logic [7:0]             hold_sym_reg, hold_sym_next;
    logic                   hold_err_reg, hold_err_next;
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_sym_reg, out_sym_next;
    logic                   out_err_reg, out_err_next;
    logic                   out_last_reg, out_last_next;

    logic out_free;
    logic match;
    logic result_now;
    logic resolve_stall;
    logic flush_stall;

    assign wr_slot  = q_cmd.slot[SLOT_W-1:0];
    assign out_free = !out_valid_reg || m_ready;
    assign q_pop    = (state_reg == BK_IDLE) && !q_status.empty;
    assign mem_wr   = q_pop && (q_cmd.kind == CMD_LOAD);

    // Entry under the scan pointer against the accumulator
    assign match = valid_reg[scan_idx_reg]
                && (rd_word_reg.length == acc_cnt_reg)
                && (rd_word_reg.code == acc_bits_reg);

    assign result_now    = found_reg || (acc_cnt_reg >= MAX_CODE_BITS);
    assign resolve_stall = result_now && hold_valid_reg && !out_free;
    assign flush_stall   = hold_valid_reg && !out_free;

    // Scan walks down from the highest loaded slot
    always_comb begin
        if (state_reg == BK_SCAN) begin
            rd_addr = scan_idx_reg - 1'b1;
        end else begin
            rd_addr = hi_slot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            mem[wr_slot] <= '{length: q_cmd.length, code: q_cmd.code, symbol: q_cmd.symbol};
        end
        rd_word_reg <= mem[rd_addr];
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_pop && q_cmd.kind == CMD_DATA) begin
                    state_next = BK_BIT;
                end
            end
            BK_BIT: begin
                state_next = any_loaded_reg ? BK_SCAN : BK_RESOLVE;
            end
            BK_SCAN: begin
                if (match || scan_idx_reg == '0) begin
                    state_next = BK_RESOLVE;
                end
            end
            BK_RESOLVE: begin
                if (!resolve_stall) begin
                    state_next = (bit_idx_reg == '0) ? BK_FLUSH : BK_BIT;
                end
            end
            BK_FLUSH: begin
                if (!flush_stall) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        valid_next      = valid_reg;
        hi_slot_next    = hi_slot_reg;
        any_loaded_next = any_loaded_reg;
        acc_bits_next   = acc_bits_reg;
        acc_cnt_next    = acc_cnt_reg;
        byte_next       = byte_reg;
        bit_idx_next    = bit_idx_reg;
        scan_idx_next   = scan_idx_reg;
        found_next      = found_reg;
        found_sym_next  = found_sym_reg;
        hold_valid_next = hold_valid_reg;
        hold_sym_next   = hold_sym_reg;
        hold_err_next   = hold_err_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_sym_next    = out_sym_reg;
        out_err_next    = out_err_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            BK_IDLE: begin
                if (q_pop) begin
                    unique case (q_cmd.kind)
                        CMD_CLEAR: begin
                            valid_next      = '0;
                            any_loaded_next = 1'b0;
                            acc_bits_next   = '0;
                            acc_cnt_next    = '0;
                        end
                        CMD_LOAD: begin
                            valid_next[wr_slot] = 1'b1;
                            any_loaded_next     = 1'b1;
                            if (!any_loaded_reg || wr_slot > hi_slot_reg) begin
                                hi_slot_next = wr_slot;
                            end
                        end
                        CMD_DATA: begin
                            byte_next    = q_cmd.data;
                            bit_idx_next = BYTE_TOP_BIT;
                        end
                        default: ;
                    endcase
                end
            end
            BK_BIT: begin
                // Shift in the next stream bit, then search
                acc_bits_next = {acc_bits_reg[CODE_W-2:0], byte_reg[bit_idx_reg]};
                acc_cnt_next  = acc_cnt_reg + 1'b1;
                scan_idx_next = hi_slot_reg;
                found_next    = 1'b0;
            end
            BK_SCAN: begin
                if (match) begin
                    found_next     = 1'b1;
                    found_sym_next = rd_word_reg.symbol;
                end else if (scan_idx_reg != '0) begin
                    scan_idx_next = scan_idx_reg - 1'b1;
                end
            end
            BK_RESOLVE: begin
                // A new result pushes the held one out, not last
                if (result_now && !resolve_stall) begin
                    if (hold_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_sym_next   = hold_sym_reg;
                        out_err_next   = hold_err_reg;
                        out_last_next  = 1'b0;
                    end
                    hold_valid_next = 1'b1;
                    hold_sym_next   = found_reg ? found_sym_reg : 8'd0;
                    hold_err_next   = !found_reg;
                    acc_bits_next   = '0;
                    acc_cnt_next    = '0;
                end
                if (!resolve_stall && bit_idx_reg != '0) begin
                    bit_idx_next = bit_idx_reg - 1'b1;
                end
            end
            BK_FLUSH: begin
                // End of byte: the held result is the last one
                if (hold_valid_reg && out_free) begin
                    out_valid_next  = 1'b1;
                    out_sym_next    = hold_sym_reg;
                    out_err_next    = hold_err_reg;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            valid_reg      <= '0;
            any_loaded_reg <= 1'b0;
            hi_slot_reg    <= '0;
            acc_bits_reg   <= '0;
            acc_cnt_reg    <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            any_loaded_reg <= any_loaded_next;
            hi_slot_reg    <= hi_slot_next;
            acc_bits_reg   <= acc_bits_next;
            acc_cnt_reg    <= acc_cnt_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            found_reg      <= found_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        byte_reg      <= byte_next;
        bit_idx_reg   <= bit_idx_next;
        scan_idx_reg  <= scan_idx_next;
        found_sym_reg <= found_sym_next;
        hold_sym_reg  <= hold_sym_next;
        hold_err_reg  <= hold_err_next;
        out_sym_reg   <= out_sym_next;
        out_err_reg   <= out_err_next;
        out_last_reg  <= out_last_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_symbol     = out_sym_reg;
    assign m_code_error = out_err_reg;
    assign m_last       = out_last_reg;

endmodule

### rtl/core/huffman_code_table_decoder_top.sv
// Huffman decoder against a loaded code table. A front stage classifies each
// input beat (clear, load, data byte; unused actions and out-of-range slots are
// dropped) into a four-entry command queue, so the input keeps taking beats
// while the back end decodes, as long as the queue has room. The back end keeps
// the table in a slot memory with one write and one registered read port, plus
// per-slot valid flags. A data byte is decoded one bit at a time: each bit
// shifts into an accumulator, then the slots are scanned walking down from the
// highest slot loaded since the last clear, stopping at the first match; the
// result side can stall the decode. The memory scan dominates the decode time:
// loading short, frequent codes into high slots keeps it short. Results leave
// through an output register, one held back per byte so the final one carries
// last.
module huffman_code_table_decoder_top import hctd_pkg::*; #(
    parameter int TABLE_SLOTS = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_action,
    input  logic [7:0]        s_entry_slot,
    input  logic [7:0]        s_entry_symbol,
    input  logic [LEN_W-1:0]  s_entry_length,
    input  logic [CODE_W-1:0] s_entry_code,
    input  logic [7:0]        s_data_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_symbol,
    output logic              m_code_error,
    output logic              m_last
);

    q_status_t q_status;
    logic      q_push;
    logic      q_pop;
    cmd_t      push_cmd;
    cmd_t      pop_cmd;

    hctd_front #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_entry_slot   (s_entry_slot),
        .s_entry_symbol (s_entry_symbol),
        .s_entry_length (s_entry_length),
        .s_entry_code   (s_entry_code),
        .s_data_byte    (s_data_byte),
        .q_status       (q_status),
        .q_push         (q_push),
        .q_cmd          (push_cmd)
    );

    hctd_cmd_fifo u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    hctd_back #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_status     (q_status),
        .q_cmd        (pop_cmd),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_symbol     (m_symbol),
        .m_code_error (m_code_error),
        .m_last       (m_last)
    );

    // An error beat never carries a symbol
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_code_error |-> m_symbol == 8'd0)
        else $error("error beat with nonzero symbol");

    // Front never pushes into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_status.full)
        else $error("command queue overflow");

    // Back never pops an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_status.empty)
        else $error("command queue underflow");

endmodule

### bench/huffman_code_table_decoder_top_tb.sv
module huffman_code_table_decoder_top_tb import hctd_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SLOTS = 256;
    // Cycles with no handshake on either side before the run is declared hung
    localparam int STUCK_LIMIT = 20000;
    // Settling time after the last result: a full command queue of bytes that
    // scan the whole table without a match
    localparam int SETTLE_CYCLES = 12000;
    // Action value that the block must ignore
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [7:0]        slot;
        logic [7:0]        symbol;
        logic [LEN_W-1:0]  length;
        logic [CODE_W-1:0] code;
        logic [7:0]        data;
    } stream_beat_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       code_error;
        logic       last;
    } decoded_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_action = ACT_CLEAR;
    logic [7:0]        s_entry_slot = '0;
    logic [7:0]        s_entry_symbol = '0;
    logic [LEN_W-1:0]  s_entry_length = '0;
    logic [CODE_W-1:0] s_entry_code = '0;
    logic [7:0]        s_data_byte = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [7:0]        m_symbol;
    logic              m_code_error;
    logic              m_last;

    // Shadow of the code table and the bit accumulator
    logic              tbl_valid [TABLE_SLOTS];
    logic [CODE_W-1:0] tbl_code [TABLE_SLOTS];
    logic [LEN_W-1:0]  tbl_len [TABLE_SLOTS];
    logic [7:0]        tbl_sym [TABLE_SLOTS];
    logic [CODE_W-1:0] acc_bits = '0;
    logic [LEN_W-1:0]  acc_count = '0;

    decoded_t decoded_q[$];
    decoded_t want;

    // Scratch for building random prefix codes
    logic [CODE_W-1:0] leaf_code[$];
    int                leaf_len[$];

    int send_idle_pct = 0;
    int sink_stall_pct = 0;
    int fail_count = 0;
    int stuck_cycles = 0;

    huffman_code_table_decoder_top #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_entry_slot   (s_entry_slot),
        .s_entry_symbol (s_entry_symbol),
        .s_entry_length (s_entry_length),
        .s_entry_code   (s_entry_code),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_symbol       (m_symbol),
        .m_code_error   (m_code_error),
        .m_last         (m_last)
    );

    always #5 aclk = ~aclk;

    // Update the shadow table and queue the results of one accepted beat
    task automatic predict_beat(input stream_beat_t beat);
        int first;
        int hit;
        int s;
        int i;
        decoded_t res;
        first = decoded_q.size();
        case (beat.action)
            ACT_CLEAR: begin
                for (s = 0; s < TABLE_SLOTS; s++)
                    tbl_valid[s] = 1'b0;
                acc_bits = '0;
                acc_count = '0;
            end
            ACT_LOAD: begin
                if (beat.slot < TABLE_SLOTS) begin
                    tbl_valid[beat.slot] = 1'b1;
                    tbl_code[beat.slot] = (beat.length < 6'd32) ?
                        (beat.code & ((32'd1 << beat.length) - 32'd1)) : beat.code;
                    tbl_len[beat.slot] = beat.length;
                    tbl_sym[beat.slot] = beat.symbol;
                end
            end
            ACT_DATA: begin
                for (i = BYTE_TOP_BIT; i >= 0; i--) begin
                    acc_bits = {acc_bits[CODE_W-2:0], beat.data[i]};
                    acc_count = acc_count + 1'b1;
                    // highest matching slot wins
                    hit = -1;
                    for (s = TABLE_SLOTS - 1; s >= 0 && hit < 0; s--)
                        if (tbl_valid[s] && tbl_len[s] == acc_count && tbl_code[s] == acc_bits)
                            hit = s;
                    if (hit >= 0) begin
                        res.symbol = tbl_sym[hit];
                        res.code_error = 1'b0;
                        res.last = 1'b0;
                        decoded_q.insert(decoded_q.size(), res);
                        acc_bits = '0;
                        acc_count = '0;
                    end else if (acc_count >= MAX_CODE_BITS) begin
                        res.symbol = 8'd0;
                        res.code_error = 1'b1;
                        res.last = 1'b0;
                        decoded_q.insert(decoded_q.size(), res);
                        acc_bits = '0;
                        acc_count = '0;
                    end
                end
                // final result of the byte carries last
                if (decoded_q.size() > first) begin
                    res = decoded_q.pop_back();
                    res.last = 1'b1;
                    decoded_q.insert(decoded_q.size(), res);
                end
            end
            default: ;
        endcase
    endtask

    function automatic stream_beat_t random_beat();
        stream_beat_t b;
        b.action = ACT_DATA;
        b.slot = 8'($urandom);
        b.symbol = 8'($urandom);
        b.length = LEN_W'($urandom);
        b.code = $urandom;
        b.data = 8'($urandom);
        return b;
    endfunction

    // Drive one beat, hold it until accepted, then predict it
    task automatic send_beat(input stream_beat_t beat);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= beat.action;
        s_entry_slot <= beat.slot;
        s_entry_symbol <= beat.symbol;
        s_entry_length <= beat.length;
        s_entry_code <= beat.code;
        s_data_byte <= beat.data;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_beat(beat);
    endtask

    task automatic clear_table();
        stream_beat_t b;
        b = random_beat();
        b.action = ACT_CLEAR;
        send_beat(b);
    endtask

    task automatic load_slot(input logic [7:0] slot, input logic [7:0] sym,
                             input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] code);
        stream_beat_t b;
        b = random_beat();
        b.action = ACT_LOAD;
        b.slot = slot;
        b.symbol = sym;
        b.length = len;
        b.code = code;
        send_beat(b);
    endtask

    task automatic feed_byte(input logic [7:0] value);
        stream_beat_t b;
        b = random_beat();
        b.action = ACT_DATA;
        b.data = value;
        send_beat(b);
    endtask

    task automatic send_unused();
        stream_beat_t b;
        b = random_beat();
        b.action = ACT_UNUSED;
        send_beat(b);
    endtask

    // Hold the input idle until every queued result has been seen
    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (decoded_q.size() != 0)
            @(posedge aclk);
    endtask

    // Empty table straight out of reset: 32 bits with no match give an error
    task automatic test_empty_table();
        send_idle_pct = 0;
        sink_stall_pct = 0;
        feed_byte(8'hFF);
        feed_byte(8'h00);
        feed_byte(8'hA5);
        feed_byte(8'h5A);
        wait_drain();
    endtask

    // Small prefix code in the top slots, one shadowed duplicate lower down
    task automatic test_code_table_basics();
        send_idle_pct = 0;
        sink_stall_pct = 0;
        clear_table();
        load_slot(8'd255, 8'h41, 6'd1, 32'h0000_0000);
        load_slot(8'd254, 8'h42, 6'd2, 32'h0000_0002);
        // code bits above the length are dropped on store
        load_slot(8'd253, 8'h43, 6'd2, 32'hFFFF_FFFF);
        load_slot(8'd128, 8'h99, 6'd1, 32'h0000_0000);
        feed_byte(8'h5C);
        feed_byte(8'hB3);
        wait_drain();
    endtask

    // Zero length, lengths past the maximum, a full 32-bit code, the unused
    // action, and a load landing while a code is half accumulated
    task automatic test_entry_corner_cases();
        send_idle_pct = 0;
        sink_stall_pct = 0;
        clear_table();
        load_slot(8'd0, 8'h11, 6'd0, 32'h0000_0000);
        load_slot(8'd1, 8'h22, 6'd63, 32'hFFFF_FFFF);
        load_slot(8'd2, 8'h33, 6'd33, 32'hFFFF_FFFF);
        load_slot(8'd3, 8'hEE, 6'd32, 32'hFFFF_FFFF);
        feed_byte(8'hFF);
        feed_byte(8'hFF);
        send_unused();
        load_slot(8'd4, 8'h44, 6'd8, 32'h0000_00FF);
        feed_byte(8'hFF);
        feed_byte(8'hFF);
        feed_byte(8'hFF);
        wait_drain();
    endtask

    // Random prefix codes, random streams, with some noise and broken runs
    task automatic test_random_streams(input int idle_pct, input int stall_pct,
                                       input int beats);
        int sent;
        int pick;
        int base;
        int n_leaves;
        int n_bytes;
        int k;
        int guard;
        int l;
        logic [CODE_W-1:0] c;
        send_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        sent = 0;
        while (sent < beats) begin
            // grow a complete prefix code by splitting leaves
            leaf_code.delete();
            leaf_len.delete();
            leaf_code.insert(0, '0);
            leaf_len.insert(0, 0);
            n_leaves = $urandom_range(2, 9);
            guard = 0;
            while (leaf_code.size() < n_leaves && guard < 100) begin
                guard++;
                pick = $urandom_range(leaf_code.size() - 1);
                if (leaf_len[pick] < 14) begin
                    c = leaf_code[pick];
                    l = leaf_len[pick];
                    leaf_code.delete(pick);
                    leaf_len.delete(pick);
                    leaf_code.insert(leaf_code.size(), {c[CODE_W-2:0], 1'b0});
                    leaf_len.insert(leaf_len.size(), l + 1);
                    leaf_code.insert(leaf_code.size(), {c[CODE_W-2:0], 1'b1});
                    leaf_len.insert(leaf_len.size(), l + 1);
                end
            end
            // some tables lose a leaf so that error results show up
            if ($urandom_range(3) == 0 && leaf_code.size() > 2) begin
                pick = $urandom_range(leaf_code.size() - 1);
                leaf_code.delete(pick);
                leaf_len.delete(pick);
            end
            clear_table();
            sent++;
            // low slots keep the table scan short
            base = $urandom_range(0, 20);
            for (k = 0; k < leaf_code.size(); k++) begin
                load_slot(8'(base + k), 8'($urandom), LEN_W'(leaf_len[k]),
                          leaf_code[k] | ($urandom << leaf_len[k]));
                sent++;
            end
            n_bytes = $urandom_range(4, 10);
            for (k = 0; k < n_bytes; k++) begin
                case ($urandom_range(15))
                    0: send_unused();
                    1: begin
                        load_slot(8'($urandom), 8'($urandom),
                                  LEN_W'($urandom_range(0, 63)), $urandom);
                        sent++;
                    end
                    2: begin
                        clear_table();
                        sent++;
                    end
                    default: ;
                endcase
                feed_byte(8'($urandom));
                sent++;
            end
        end
        wait_drain();
    endtask

    // Result side: random backpressure and in-order field compare
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected beat: symbol %0h code_error %0b last %0b",
                           m_symbol, m_code_error, m_last);
                    fail_count++;
                end else begin
                    want = decoded_q.pop_front();
                    if (m_symbol !== want.symbol) begin
                        $error("symbol: expected %0h, got %0h", want.symbol, m_symbol);
                        fail_count++;
                    end
                    if (m_code_error !== want.code_error) begin
                        $error("code_error: expected %0b, got %0b",
                               want.code_error, m_code_error);
                        fail_count++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_last);
                        fail_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Hang detection: count cycles with work pending and no beat moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) ||
            (!s_valid && decoded_q.size() == 0)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("huffman_code_table_decoder_top_tb NOT OK");
            $finish;
        end
    end

    initial begin
        int s;
        // shadow table starts empty, as after reset
        for (s = 0; s < TABLE_SLOTS; s++)
            tbl_valid[s] = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_code_table_basics();
        test_entry_corner_cases();
        test_random_streams(0, 0, 15);
        test_random_streams(82, 0, 15);
        test_random_streams(0, 82, 15);
        test_random_streams(8, 8, 15);

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("huffman_code_table_decoder_top_tb OK");
        end else begin
            $display("huffman_code_table_decoder_top_tb NOT OK");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/hctd_pkg.sv
rtl/core/hctd_front.sv
rtl/core/hctd_cmd_fifo.sv
rtl/core/hctd_back.sv
rtl/core/huffman_code_table_decoder_top.sv
bench/huffman_code_table_decoder_top_tb.sv
